@@ sv/htnm_pkg.sv @@
// htnm_pkg: widths, constants and the per-lane search record
// for the height to normal map pipeline; no dependencies
`timescale 1ns / 1ps

package htnm_pkg;

   // input sample and register widths
   localparam int HEIGHT_BITS = 8;
   localparam int CFG_BITS    = 16;
   localparam int ZFRAC_BITS  = 8;
   localparam logic [CFG_BITS-1:0] Z_SCALE_RESET = 16'd256;

   // largest height code, the 1/255 scale
   localparam int HMAX = (1 << HEIGHT_BITS) - 1;

   // derived datapath widths
   localparam int MAG_BITS  = HEIGHT_BITS;
   localparam int SQ_BITS   = 2 * HEIGHT_BITS;
   localparam int XSQ_SHIFT = 2 * ZFRAC_BITS;
   localparam int Z_BITS    = CFG_BITS + HEIGHT_BITS;
   localparam int ZSQ_BITS  = 2 * Z_BITS;
   localparam int S_BITS    = ZSQ_BITS + 1;

   // encoded output: 8 bits, searched one bit per stage
   localparam int K_BITS  = 8;
   localparam int T_SHIFT = 14;
   localparam int AW      = S_BITS + 2 * K_BITS + 1;
   localparam logic [K_BITS-1:0] ENC_MID      = 8'd127;
   localparam logic [K_BITS-1:0] ENC_NEG_BASE = 8'd126;

   // lane codes
   localparam int LANE_RED   = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_BLUE  = 2;
   localparam int NUM_LANES  = 3;

   // pipeline layout: three front stages, one per search bit, one output stage
   localparam int FRONT_STAGES = 3;
   localparam int NSTAGE       = FRONT_STAGES + K_BITS + 1;

   // running state of one component's search
   // p = n*n*S, q = n*S, t = 16384*c*c, strict for a negative component
   typedef struct packed {
      logic [AW-1:0]     p;
      logic [AW-1:0]     q;
      logic [AW-1:0]     t;
      logic [K_BITS-1:0] n;
      logic              strict;
   } lane_type;

endpackage

@@ sv/htnm_root_step.sv @@
// htnm_root_step: one registered bit of the ratio search for one lane
// depends on htnm_pkg
`timescale 1ns / 1ps

module htnm_root_step #(
   parameter int BIT = 0
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [htnm_pkg::S_BITS-1:0]  s,
   input  htnm_pkg::lane_type           lane_in,
   output htnm_pkg::lane_type           lane_out
);

   localparam int QSH = BIT + 1;
   localparam int SSH = 2 * BIT;

   logic [htnm_pkg::AW-1:0] trial;
   logic                    ok;
   htnm_pkg::lane_type      lane_in_w;
   htnm_pkg::lane_type      lane_ff;

   // (n + 2^b)^2 * S = p + q * 2^(b+1) + S * 2^(2b)
   always_comb begin
      trial = lane_in.p + (lane_in.q << QSH) + (htnm_pkg::AW'(s) << SSH);
      ok    = lane_in.strict ? (trial < lane_in.t) : (trial <= lane_in.t);
      lane_in_w = lane_in;
      if (ok) begin
         lane_in_w.p = trial;
         lane_in_w.q = lane_in.q + (htnm_pkg::AW'(s) << BIT);
         lane_in_w.n = lane_in.n | (htnm_pkg::K_BITS'(1) << BIT);
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in_w;
      end
   end

   assign lane_out = lane_ff;

endmodule

@@ sv/height_to_normal_map_top.sv @@
// height_to_normal_map_top: finite-difference normal encoder, twelve stages
// throughput one pixel per cycle while rsp_ready holds the output open
// the depth comes from the eight-stage bit search per component (one bit per stage)
// stages hold on a stalled output and fill bubbles; ready drops only with all stages full
// reset (synchronous) empties the pipeline and sets z_scale to 256 (1.0)
`timescale 1ns / 1ps

module height_to_normal_map_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [htnm_pkg::HEIGHT_BITS-1:0]  req_height_center,
   input  logic [htnm_pkg::HEIGHT_BITS-1:0]  req_height_right,
   input  logic [htnm_pkg::HEIGHT_BITS-1:0]  req_height_back,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [htnm_pkg::K_BITS-1:0]       rsp_normal_red,
   output logic [htnm_pkg::K_BITS-1:0]       rsp_normal_green,
   output logic [htnm_pkg::K_BITS-1:0]       rsp_normal_blue,
   input  logic                              csr_wr_en,
   input  logic [htnm_pkg::CFG_BITS-1:0]     csr_wr_data
);

   localparam int NS    = htnm_pkg::NSTAGE;
   localparam int NK    = htnm_pkg::K_BITS;
   localparam int NL    = htnm_pkg::NUM_LANES;
   localparam int FS    = htnm_pkg::FRONT_STAGES;
   localparam int LAST  = NS - 1;
   localparam int LSTEP = LAST - 1;

   logic [htnm_pkg::CFG_BITS-1:0] z_scale_ff;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS:0]   move;

   // stage 0
   logic [htnm_pkg::HEIGHT_BITS:0]   d_r;
   logic [htnm_pkg::HEIGHT_BITS:0]   d_g;
   logic [htnm_pkg::HEIGHT_BITS:0]   d_r_neg;
   logic [htnm_pkg::HEIGHT_BITS:0]   d_g_neg;
   logic [htnm_pkg::MAG_BITS-1:0]    mag_r_ff;
   logic [htnm_pkg::MAG_BITS-1:0]    mag_g_ff;
   logic                             neg0_r_ff;
   logic                             neg0_g_ff;
   logic [htnm_pkg::Z_BITS-1:0]      z_ff;

   // stage 1
   logic [htnm_pkg::SQ_BITS-1:0]     sq_r_ff;
   logic [htnm_pkg::SQ_BITS-1:0]     sq_g_ff;
   logic [htnm_pkg::ZSQ_BITS-1:0]    zsq_ff;
   logic                             neg1_r_ff;
   logic                             neg1_g_ff;

   // stage 2 and the search chain
   htnm_pkg::lane_type               lane2_ff [NL];
   htnm_pkg::lane_type               lane_w   [NL][NK+1];
   logic [htnm_pkg::S_BITS-1:0]      s_pipe_ff    [NK+1];
   logic                             zero_pipe_ff [NK+1];

   // output stage
   logic [NK-1:0] red_ff;
   logic [NK-1:0] green_ff;
   logic [NK-1:0] blue_ff;

   // map search count to the encoded component
   function automatic logic [NK-1:0] encode_k(input htnm_pkg::lane_type l, input logic zero);
      logic [NK-1:0] k;
      if (zero) begin
         k = htnm_pkg::ENC_MID;
      end else if (!l.strict) begin
         k = htnm_pkg::ENC_MID + l.n;
      end else if (l.n == htnm_pkg::ENC_MID) begin
         k = '0;
      end else begin
         k = htnm_pkg::ENC_NEG_BASE - l.n;
      end
      return k;
   endfunction

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         z_scale_ff <= htnm_pkg::Z_SCALE_RESET;
      end else if (csr_wr_en) begin
         z_scale_ff <= csr_wr_data;
      end
   end

   // stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      move[NS] = rsp_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         move[i] = !v_ff[i] || move[i+1];
      end
      v_in = v_ff;
      if (move[0]) begin
         v_in[0] = req_valid;
      end
      for (int i = 1; i < NS; i++) begin
         if (move[i]) begin
            v_in[i] = v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = move[0];

   // stage 0: differences, magnitudes, scaled z
   always_comb begin
      d_r     = {1'b0, req_height_center} - {1'b0, req_height_back};
      d_g     = {1'b0, req_height_center} - {1'b0, req_height_right};
      d_r_neg = -d_r;
      d_g_neg = -d_g;
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         neg0_r_ff <= d_r[htnm_pkg::HEIGHT_BITS];
         neg0_g_ff <= d_g[htnm_pkg::HEIGHT_BITS];
         mag_r_ff  <= d_r[htnm_pkg::HEIGHT_BITS] ? d_r_neg[htnm_pkg::MAG_BITS-1:0]
                                                  : d_r[htnm_pkg::MAG_BITS-1:0];
         mag_g_ff  <= d_g[htnm_pkg::HEIGHT_BITS] ? d_g_neg[htnm_pkg::MAG_BITS-1:0]
                                                  : d_g[htnm_pkg::MAG_BITS-1:0];
         z_ff      <= htnm_pkg::Z_BITS'(z_scale_ff) * htnm_pkg::Z_BITS'(htnm_pkg::HMAX);
      end
   end

   // stage 1: squares
   always_ff @(posedge clock) begin
      if (move[1]) begin
         sq_r_ff   <= htnm_pkg::SQ_BITS'(mag_r_ff) * htnm_pkg::SQ_BITS'(mag_r_ff);
         sq_g_ff   <= htnm_pkg::SQ_BITS'(mag_g_ff) * htnm_pkg::SQ_BITS'(mag_g_ff);
         zsq_ff    <= htnm_pkg::ZSQ_BITS'(z_ff) * htnm_pkg::ZSQ_BITS'(z_ff);
         neg1_r_ff <= neg0_r_ff;
         neg1_g_ff <= neg0_g_ff;
      end
   end

   // stage 2: squared length and search targets
   always_ff @(posedge clock) begin
      if (move[2]) begin
         s_pipe_ff[0]    <= (htnm_pkg::S_BITS'(sq_r_ff) << htnm_pkg::XSQ_SHIFT)
                          + (htnm_pkg::S_BITS'(sq_g_ff) << htnm_pkg::XSQ_SHIFT)
                          + htnm_pkg::S_BITS'(zsq_ff);
         zero_pipe_ff[0] <= (sq_r_ff == '0) && (sq_g_ff == '0) && (zsq_ff == '0);

         lane2_ff[htnm_pkg::LANE_RED] <= '{
            p: '0, q: '0, n: '0, strict: neg1_r_ff,
            t: htnm_pkg::AW'(sq_r_ff) << (htnm_pkg::XSQ_SHIFT + htnm_pkg::T_SHIFT)};
         lane2_ff[htnm_pkg::LANE_GREEN] <= '{
            p: '0, q: '0, n: '0, strict: neg1_g_ff,
            t: htnm_pkg::AW'(sq_g_ff) << (htnm_pkg::XSQ_SHIFT + htnm_pkg::T_SHIFT)};
         lane2_ff[htnm_pkg::LANE_BLUE] <= '{
            p: '0, q: '0, n: '0, strict: 1'b0,
            t: htnm_pkg::AW'(zsq_ff) << htnm_pkg::T_SHIFT};
      end
   end

   // search chain: one bit of each component per stage, msb first
   for (genvar c = 0; c < NL; c++) begin : g_lane
      assign lane_w[c][0] = lane2_ff[c];
      for (genvar j = 0; j < NK; j++) begin : g_step
         htnm_root_step #(
            .BIT(NK - 1 - j)
         ) u_step (
            .clock   (clock),
            .en      (move[FS+j]),
            .s       (s_pipe_ff[j]),
            .lane_in (lane_w[c][j]),
            .lane_out(lane_w[c][j+1])
         );
      end
   end

   // length and zero flag ride along with the search
   for (genvar j = 0; j < NK; j++) begin : g_side
      always_ff @(posedge clock) begin
         if (move[FS+j]) begin
            s_pipe_ff[j+1]    <= s_pipe_ff[j];
            zero_pipe_ff[j+1] <= zero_pipe_ff[j];
         end
      end
   end

   // output stage: encode
   always_ff @(posedge clock) begin
      if (move[LAST]) begin
         red_ff   <= encode_k(lane_w[htnm_pkg::LANE_RED][NK],   zero_pipe_ff[NK]);
         green_ff <= encode_k(lane_w[htnm_pkg::LANE_GREEN][NK], zero_pipe_ff[NK]);
         blue_ff  <= encode_k(lane_w[htnm_pkg::LANE_BLUE][NK],  zero_pipe_ff[NK]);
      end
   end

   assign rsp_valid        = v_ff[LAST];
   assign rsp_normal_red   = red_ff;
   assign rsp_normal_green = green_ff;
   assign rsp_normal_blue  = blue_ff;

   // a negative red component never reaches a full 128 count
   a_neg_count: assert property (@(posedge clock) disable iff (reset)
      v_ff[LSTEP] && lane_w[htnm_pkg::LANE_RED][NK].strict
      |-> !lane_w[htnm_pkg::LANE_RED][NK].n[NK-1])
      else $error("negative red component searched past 127");

   // a non-negative blue component counts at most 128 unless the vector is zero
   a_pos_count: assert property (@(posedge clock) disable iff (reset)
      v_ff[LSTEP] && !zero_pipe_ff[NK] && !lane_w[htnm_pkg::LANE_BLUE][NK].strict
      |-> (!lane_w[htnm_pkg::LANE_BLUE][NK].n[NK-1]
           || (lane_w[htnm_pkg::LANE_BLUE][NK].n[NK-2:0] == '0)))
      else $error("blue component count above 128");

   // input is held off only when every stage holds an item
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&v_ff))
      else $error("input stalled with a bubble in the pipeline");

endmodule
